// ===== rtl/tal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tal_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int DIV_W           = 50;
    localparam int QDEPTH          = 2;
    localparam int QAW             = 1;

    localparam logic [23:0] RES_MAX       = 24'hFFFFFF;
    localparam logic [23:0] OFS_DIVISOR   = 24'd10;
    localparam logic [23:0] FILT_DIVISOR  = 24'd20;
    localparam logic [4:0]  FILT_OLD_WT   = 5'd19;

    // reciprocal of 10 for a 19-bit dividend, of 5 for a 28-bit dividend
    localparam logic [23:0] OFS_RECIP     = 24'd13421773;
    localparam int          OFS_SHIFT     = 27;
    localparam logic [27:0] FILT_RECIP    = 28'd214748365;
    localparam int          FILT_SHIFT    = 30;

    typedef struct packed {
        logic               func;
        logic [15:0]        current_sample;
        logic [15:0]        voltage_sample;
        logic [5:0]         table_index;
        logic signed [15:0] table_temp;
        logic [23:0]        table_resistance;
    } item_t;

    typedef struct packed {
        logic [23:0]        resistance_ohms;
        logic signed [23:0] temperature;
        logic signed [23:0] filtered_temp;
        logic               open_sensor;
    } result_t;

    typedef struct packed {
        logic [7:0]         average_count;
        logic [15:0]        reference_resistance;
        logic signed [10:0] offset_tenths;
        logic [23:0]        open_threshold;
        logic [6:0]         table_length;
    } cfg_t;

    typedef struct packed {
        logic               is_table;
        logic [23:0]        csum;
        logic [23:0]        vsum;
        logic [7:0]         cnt;
        logic [5:0]         idx;
        logic signed [15:0] ttemp;
        logic [23:0]        tres;
    } job_t;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [23:0]        res;
    } entry_t;

    typedef enum logic [2:0] {
        REG_AVERAGE_COUNT  = 3'd0,
        REG_REFERENCE_RES  = 3'd1,
        REG_OFFSET_TENTHS  = 3'd2,
        REG_OPEN_THRESHOLD = 3'd3,
        REG_TABLE_LENGTH   = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AVGI,
        S_AVGV,
        S_MUL,
        S_RESL,
        S_RES,
        S_OFS,
        S_OFSW,
        S_WRD,
        S_WCMP,
        S_RDA,
        S_RDB,
        S_DIFF,
        S_MULI,
        S_FRACL,
        S_FRAC,
        S_SUM,
        S_FILT,
        S_FLAUNCH,
        S_FDIV,
        S_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/tal_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tal_front
    import tal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    input  wire logic [7:0] average_count,
    output job_t       job,
    output logic       job_push,
    input  wire logic  job_full
);

    localparam logic [15:0] SMASK = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [23:0] csum_reg, csum_next;
    logic [23:0] vsum_reg, vsum_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  target;
    logic        accept;
    logic        close;

    assign full      = job_full;
    assign accept    = push && !job_full;
    assign target    = (average_count == 8'd0) ? 8'd1 : average_count;
    assign csum_next = csum_reg + 24'(item.current_sample & SMASK);
    assign vsum_next = vsum_reg + 24'(item.voltage_sample & SMASK);
    assign cnt_next  = cnt_reg + 8'd1;
    assign close     = (cnt_next >= target);

    always_comb
    begin
        job.is_table = item.func;
        job.csum     = csum_next;
        job.vsum     = vsum_next;
        job.cnt      = cnt_next;
        job.idx      = item.table_index;
        job.ttemp    = item.table_temp;
        job.tres     = item.table_resistance;
        job_push     = accept && (item.func || close);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg <= '0;
            vsum_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (accept && !item.func)
        begin
            if (close)
            begin
                csum_reg <= '0;
                vsum_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                csum_reg <= csum_next;
                vsum_reg <= vsum_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tal_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tal_fifo
    import tal_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wdata,
    output logic      full,
    input  wire logic pop,
    output job_t      rdata,
    output logic      empty
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tal_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tal_div
    import tal_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [23:0]      divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNTW = $clog2(DIV_W + 1);

    logic [23:0]      rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [23:0]      dvs_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [24:0]      shifted;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 24'(shifted - {1'b0, dvs_reg}) : shifted[23:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNTW'(1));
            if (start)
            begin
                cnt_reg  <= CNTW'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tal_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tal_back
    import tal_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire job_t job,
    input  wire logic job_empty,
    output logic      job_pop,
    output result_t   result,
    output logic      empty,
    input  wire logic pop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    back_state_t state_reg, state_next;

    entry_t  table_mem [TABLE_DEPTH];
    entry_t  rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          tab_we;
    logic          idx_ok;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [23:0]      div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic [23:0]        vsum_reg;
    logic [7:0]         cnt_reg;
    logic [23:0]        avg_i_reg;
    logic [23:0]        avg_v_reg;
    logic [39:0]        prod_reg;
    logic [23:0]        res_reg;
    logic               open_reg;
    logic [42:0]        ofs_prod_reg;
    logic signed [16:0] ofs_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      a_reg;
    logic [AW-1:0]      b_reg;
    logic signed [15:0] ta_reg;
    logic [23:0]        ra_reg;
    logic signed [16:0] dt_reg;
    logic signed [24:0] dr_reg;
    logic signed [24:0] dx_reg;
    logic signed [41:0] num_reg;
    logic signed [50:0] frac_reg;
    logic signed [23:0] t_reg;
    logic signed [29:0] fnum_reg;
    logic [55:0]        fprod_reg;
    logic signed [23:0] filt_reg;
    logic signed [23:0] smooth_reg;
    logic               out_valid_reg;
    result_t            result_reg;

    logic [CW-1:0]      tl;
    logic [CW-1:0]      len;
    logic               hit;
    logic               last;
    logic               out_free;
    logic [10:0]        off_mag;
    logic [18:0]        ofs_x;
    logic [41:0]        num_mag;
    logic [24:0]        dr_mag;
    logic [29:0]        fnum_mag;
    logic [27:0]        filt_y;
    logic [23:0]        res_sat;
    logic signed [16:0] ofs_q;
    logic signed [50:0] frac_q;
    logic signed [23:0] filt_q;
    logic signed [51:0] tsum;

    assign tl  = CW'(cfg.table_length);
    assign len = (tl < CW'(2)) ? CW'(2) : ((tl > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : tl);
    assign hit  = !(res_reg < rd_data_reg.res);
    assign last = ((CW'(i_reg) + CW'(2)) == len);
    assign out_free = !out_valid_reg || pop;
    assign idx_ok   = (32'(job.idx) < 32'(TABLE_DEPTH));

    assign off_mag  = cfg.offset_tenths[10] ? 11'(-cfg.offset_tenths) : 11'(cfg.offset_tenths);
    assign ofs_x    = {off_mag, 8'd0} + 19'(OFS_DIVISOR >> 1);
    assign num_mag  = num_reg[41] ? 42'(-num_reg) : 42'(num_reg);
    assign dr_mag   = dr_reg[24] ? 25'(-dr_reg) : 25'(dr_reg);
    assign fnum_mag = fnum_reg[29] ? 30'(-fnum_reg) : 30'(fnum_reg);
    assign filt_y   = 28'((fnum_mag + 30'(FILT_DIVISOR >> 1)) >> 2);
    assign res_sat  = (div_quo[DIV_W-1:24] != '0) ? RES_MAX : div_quo[23:0];
    assign ofs_q    = 17'({1'b0, ofs_prod_reg[OFS_SHIFT+15:OFS_SHIFT]});
    assign frac_q   = 51'(div_quo);
    assign filt_q   = fprod_reg[FILT_SHIFT+23:FILT_SHIFT];
    assign tsum     = 52'($signed({ta_reg, 8'd0})) + 52'(frac_reg) + 52'(ofs_reg);

    assign result = result_reg;
    assign empty  = !out_valid_reg;

    tal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            table_mem[AW'(job.idx)] <= '{temp: job.ttemp, res: job.tres};
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (!job_empty && !job.is_table) state_next = S_AVGI;
            S_AVGI:    if (div_done) state_next = S_AVGV;
            S_AVGV:    if (div_done) state_next = S_MUL;
            S_MUL:     state_next = S_RESL;
            S_RESL:    state_next = (avg_i_reg == '0) ? S_OFS : S_RES;
            S_RES:     if (div_done) state_next = S_OFS;
            S_OFS:     state_next = S_OFSW;
            S_OFSW:    state_next = S_WRD;
            S_WRD:     state_next = S_WCMP;
            S_WCMP:    state_next = (hit || last) ? S_RDA : S_WRD;
            S_RDA:     state_next = S_RDB;
            S_RDB:     state_next = S_DIFF;
            S_DIFF:    state_next = S_MULI;
            S_MULI:    state_next = S_FRACL;
            S_FRACL:   state_next = (dr_reg == '0) ? S_SUM : S_FRAC;
            S_FRAC:    if (div_done) state_next = S_SUM;
            S_SUM:     state_next = S_FILT;
            S_FILT:    state_next = S_FLAUNCH;
            S_FLAUNCH: state_next = S_FDIV;
            S_FDIV:    state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop      = (state_reg == S_IDLE) && !job_empty;
        tab_we       = job_pop && job.is_table && idx_ok;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 24'd1;
        rd_addr      = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start    = job_pop && !job.is_table;
                div_dividend = DIV_W'(job.csum);
                div_divisor  = 24'(job.cnt);
            end
            S_AVGI:
            begin
                div_start    = div_done;
                div_dividend = DIV_W'(vsum_reg);
                div_divisor  = 24'(cnt_reg);
            end
            S_RESL:
            begin
                div_start    = (avg_i_reg != '0);
                div_dividend = DIV_W'(prod_reg);
                div_divisor  = avg_i_reg;
            end
            S_RDA:   rd_addr = a_reg;
            S_RDB:   rd_addr = b_reg;
            S_FRACL:
            begin
                div_start    = (dr_reg != '0);
                div_dividend = DIV_W'({num_mag, 8'd0}) + DIV_W'(dr_mag >> 1);
                div_divisor  = dr_mag[23:0];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                vsum_reg <= job.vsum;
                cnt_reg  <= job.cnt;
            end
            S_AVGI:  if (div_done) avg_i_reg <= div_quo[23:0];
            S_AVGV:  if (div_done) avg_v_reg <= div_quo[23:0];
            S_MUL:   prod_reg <= 40'(avg_v_reg) * 40'(cfg.reference_resistance);
            S_RESL:
            begin
                res_reg  <= RES_MAX;
                open_reg <= 1'b1;
            end
            S_RES:
            begin
                if (div_done)
                begin
                    res_reg  <= res_sat;
                    open_reg <= (res_sat > cfg.open_threshold);
                end
            end
            S_OFS:   ofs_prod_reg <= 43'(ofs_x) * 43'(OFS_RECIP);
            S_OFSW:
            begin
                ofs_reg <= cfg.offset_tenths[10] ? -ofs_q : ofs_q;
                i_reg   <= '0;
            end
            S_WCMP:
            begin
                if (hit)
                begin
                    a_reg <= i_reg;
                    b_reg <= i_reg + 1'b1;
                end
                else if (last)
                begin
                    a_reg <= i_reg + 1'b1;
                    b_reg <= i_reg;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            S_RDB:
            begin
                ta_reg <= rd_data_reg.temp;
                ra_reg <= rd_data_reg.res;
            end
            S_DIFF:
            begin
                dt_reg <= 17'(rd_data_reg.temp) - 17'(ta_reg);
                dr_reg <= $signed({1'b0, rd_data_reg.res}) - $signed({1'b0, ra_reg});
                dx_reg <= $signed({1'b0, res_reg}) - $signed({1'b0, ra_reg});
            end
            S_MULI:  num_reg <= 42'(dx_reg) * 42'(dt_reg);
            S_FRACL: frac_reg <= '0;
            S_FRAC:
            begin
                if (div_done)
                begin
                    frac_reg <= (num_reg[41] ^ dr_reg[24]) ? -frac_q : frac_q;
                end
            end
            S_SUM:
            begin
                if (tsum > 52'sd8388607)
                begin
                    t_reg <= 24'sh7FFFFF;
                end
                else if (tsum < -52'sd8388608)
                begin
                    t_reg <= 24'sh800000;
                end
                else
                begin
                    t_reg <= 24'(tsum);
                end
            end
            S_FILT:    fnum_reg <= 30'(smooth_reg) * $signed({25'd0, FILT_OLD_WT}) + 30'(t_reg);
            S_FLAUNCH: fprod_reg <= 56'(filt_y) * 56'(FILT_RECIP);
            S_FDIV:    filt_reg <= fnum_reg[29] ? -filt_q : filt_q;
            S_OUT:
            begin
                if (out_free)
                begin
                    result_reg <= '{resistance_ohms: res_reg, temperature: t_reg,
                                    filtered_temp: filt_reg, open_sensor: open_reg};
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            smooth_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                smooth_reg    <= filt_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/thermistor_average_linearize_filter.sv =====
// output: only a sample beat that closes a window gives a result; table beats and
//   other samples give none
// throughput: beats are taken one a cycle while the two-entry job queue has room;
//   one window is worked at a time, bounded by four runs of the serial divider and
//   a table walk through a read state and a compare state per entry
// reset: clears sums, count, filter, queue, state and configuration registers; the table is undefined until written
`timescale 1ns / 1ps
`default_nettype none
module thermistor_average_linearize_filter
    import tal_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       item,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t cfg_reg;
    job_t fr_job;
    job_t bk_job;
    logic fr_push;
    logic q_full;
    logic q_empty;
    logic bk_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.average_count        <= 8'd16;
            cfg_reg.reference_resistance <= 16'd3005;
            cfg_reg.offset_tenths        <= '0;
            cfg_reg.open_threshold       <= 24'd1000000;
            cfg_reg.table_length         <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AVERAGE_COUNT:  cfg_reg.average_count        <= cfg_data[7:0];
                REG_REFERENCE_RES:  cfg_reg.reference_resistance <= cfg_data[15:0];
                REG_OFFSET_TENTHS:  cfg_reg.offset_tenths        <= cfg_data[10:0];
                REG_OPEN_THRESHOLD: cfg_reg.open_threshold       <= cfg_data;
                REG_TABLE_LENGTH:   cfg_reg.table_length         <= cfg_data[6:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    tal_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .average_count (cfg_reg.average_count),
        .job           (fr_job),
        .job_push      (fr_push),
        .job_full      (q_full)
    );

    tal_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_job),
        .full  (q_full),
        .pop   (bk_pop),
        .rdata (bk_job),
        .empty (q_empty)
    );

    tal_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (bk_job),
        .job_empty (q_empty),
        .job_pop   (bk_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
`default_nettype wire

// ===== rtl/tal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tal_checker
    import tal_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire item_t       item,
    input wire logic        empty,
    input wire logic        pop,
    input wire result_t     result,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [23:0] cfg_data
);

    // a zero resistance can never be above any threshold
    a_zero_not_open: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.resistance_ohms == 24'd0)) |-> !result.open_sensor)
        else $error("open flag with zero resistance");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

endmodule

bind thermistor_average_linearize_filter tal_checker u_tal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
`default_nettype wire

// ===== tb/sv/thermistor_average_linearize_filter_tb.sv =====
`timescale 1ns / 1ps
module thermistor_average_linearize_filter_tb;
    import tal_pkg::*;

    localparam int DEPTH = 64;
    localparam int DRAIN_CYCLES = 500;
    localparam int STALL_LIMIT = 40000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    item_t       item = '0;
    logic        empty;
    logic        pop = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    thermistor_average_linearize_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [7:0]         avg_count_q;
    logic [15:0]        ref_res_q;
    logic signed [10:0] offset_q;
    logic [23:0]        open_thr_q;
    logic [6:0]         tab_len_q;
    logic [23:0]        csum_q;
    logic [23:0]        vsum_q;
    logic [7:0]         count_q;
    logic signed [23:0] smooth_q;
    logic signed [15:0] curve_temp [DEPTH];
    logic [23:0]        curve_res [DEPTH];

    result_t readings_due[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      sink_hold = 1'b0;
    bit      quiet = 1'b0;
    int      sink_hold_cycles = 0;

    function automatic longint div_nearest(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        if (ud == 0)
            return 0;
        q = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint interpolate_q8(logic [23:0] r);
        int     len;
        int     i;
        int     a;
        int     b;
        longint dt;
        longint dr;
        longint frac;
        len = tab_len_q;
        if (len < 2) len = 2;
        if (len > DEPTH) len = DEPTH;
        i = 0;
        forever
        begin
            if (!(r < curve_res[i]))
            begin
                a = i;
                b = i + 1;
                break;
            end
            i++;
            if (i + 1 == len)
            begin
                a = i;
                b = i - 1;
                break;
            end
        end
        dt = longint'(curve_temp[b]) - longint'(curve_temp[a]);
        dr = longint'(curve_res[b]) - longint'(curve_res[a]);
        frac = (dr == 0) ? 0 : div_nearest((longint'(r) - longint'(curve_res[a])) * dt * 256, dr);
        return longint'(curve_temp[a]) * 256 + frac;
    endfunction

    function automatic void predict_reading(item_t it);
        int          target;
        int          cnt;
        longint      avg_i;
        longint      avg_v;
        longint      q;
        logic [23:0] res;
        bit          open;
        longint      t;
        longint      filt;
        result_t     r;
        if (it.func)
        begin
            curve_temp[it.table_index] = it.table_temp;
            curve_res[it.table_index] = it.table_resistance;
            return;
        end
        csum_q = csum_q + it.current_sample;
        vsum_q = vsum_q + it.voltage_sample;
        count_q = count_q + 1;
        target = avg_count_q == 0 ? 1 : avg_count_q;
        if (count_q < target)
            return;
        cnt = count_q == 0 ? 1 : count_q;
        avg_i = csum_q / cnt;
        avg_v = vsum_q / cnt;
        if (avg_i == 0)
        begin
            res = 24'hFFFFFF;
            open = 1'b1;
        end
        else
        begin
            q = avg_v * ref_res_q / avg_i;
            res = q > 64'hFFFFFF ? 24'hFFFFFF : q[23:0];
            open = res > open_thr_q;
        end
        t = interpolate_q8(res) + div_nearest(longint'(offset_q) * 256, 10);
        if (t > 8388607) t = 8388607;
        if (t < -8388608) t = -8388608;
        filt = div_nearest(longint'(smooth_q) * 19 + t, 20);
        smooth_q = filt[23:0];
        csum_q = '0;
        vsum_q = '0;
        count_q = '0;
        r.resistance_ohms = res;
        r.temperature = t[23:0];
        r.filtered_temp = filt[23:0];
        r.open_sensor = open;
        readings_due.push_back(r);
    endfunction

    // result side: random stall bursts plus a long hold
    always @(posedge clk)
    begin
        if (sink_hold)
            sink_hold_cycles <= sink_hold_cycles + 1;
        if (!rst_n || sink_hold)
            pop <= 1'b0;
        else if (quiet)
            pop <= 1'b1;
        else if (!pop || $urandom_range(0, 7) != 0)
            pop <= ($urandom_range(0, 5) != 0);
        else
            pop <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (readings_due.size() == 0)
            begin
                $error("unexpected result beat %p", result);
                errors++;
            end
            else
            begin
                result_t e;
                e = readings_due.pop_front();
                if (result.resistance_ohms !== e.resistance_ohms)
                begin
                    $error("resistance_ohms exp %0d got %0d", e.resistance_ohms,
                           result.resistance_ohms);
                    errors++;
                end
                if (result.temperature !== e.temperature)
                begin
                    $error("temperature exp %0d got %0d", e.temperature, result.temperature);
                    errors++;
                end
                if (result.filtered_temp !== e.filtered_temp)
                begin
                    $error("filtered_temp exp %0d got %0d", e.filtered_temp,
                           result.filtered_temp);
                    errors++;
                end
                if (result.open_sensor !== e.open_sensor)
                begin
                    $error("open_sensor exp %0d got %0d", e.open_sensor, result.open_sensor);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        predict_reading(it);
    endtask

    task automatic send_sample(logic [15:0] ci, logic [15:0] vi);
        item_t it;
        it = '0;
        it.func = 1'b0;
        it.current_sample = ci;
        it.voltage_sample = vi;
        it.table_index = 6'($urandom);
        it.table_temp = 16'($urandom);
        it.table_resistance = 24'($urandom);
        send_item(it);
    endtask

    task automatic send_entry(int idx, int tmp, int res);
        item_t it;
        it = '0;
        it.func = 1'b1;
        it.current_sample = 16'($urandom);
        it.voltage_sample = 16'($urandom);
        it.table_index = idx[5:0];
        it.table_temp = tmp[15:0];
        it.table_resistance = res[23:0];
        send_item(it);
    endtask

    task automatic settle();
        push <= 1'b0;
        wait (readings_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_AVERAGE_COUNT:  avg_count_q = data[7:0];
            REG_REFERENCE_RES:  ref_res_q = data[15:0];
            REG_OFFSET_TENTHS:  offset_q = data[10:0];
            REG_OPEN_THRESHOLD: open_thr_q = data;
            REG_TABLE_LENGTH:   tab_len_q = data[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // sorted by falling resistance, random content
    task automatic load_curve(bit extreme);
        int r;
        int tmp;
        r = extreme ? 24'hFFFFF0 : $urandom_range(200000, 4000000);
        tmp = extreme ? -32768 : $urandom_range(0, 200) - 100;
        for (int k = 0; k < DEPTH; k++)
        begin
            send_entry(k, tmp, r);
            if (extreme && k == DEPTH - 2)
                r = 0;
            else if ($urandom_range(0, 9) != 0)
                r = r - $urandom_range(0, r / 8 + 1);
            if (r < 0) r = 0;
            tmp = extreme ? (k == DEPTH - 2 ? 32767 : tmp + 1000) : tmp + $urandom_range(0, 8);
            if (tmp > 32767) tmp = 32767;
        end
    endtask

    task automatic test_directed();
        write_reg(REG_AVERAGE_COUNT, 24'd1);
        load_curve(1'b1);
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'd1, 16'hFFFF);
        send_sample(16'hFFFF, 16'd0);
        send_entry(0, 16'sh7FFF, 24'hFFFFFF);
        send_sample(16'd1, 16'd1);
        settle();
        write_reg(REG_AVERAGE_COUNT, 24'd0);
        write_reg(REG_REFERENCE_RES, 24'd65535);
        write_reg(REG_OFFSET_TENTHS, 24'h400 + 24'd1048);
        write_reg(REG_OPEN_THRESHOLD, 24'd0);
        write_reg(REG_TABLE_LENGTH, 24'd2);
        send_sample(16'd3, 16'hFFFF);
        send_sample(16'd0, 16'd5);
        settle();
        write_reg(REG_OFFSET_TENTHS, 24'd1000);
        write_reg(REG_OPEN_THRESHOLD, 24'hFFFFFF);
        write_reg(REG_TABLE_LENGTH, 24'd1);
        send_sample(16'd1000, 16'd2000);
        settle();
        write_reg(REG_TABLE_LENGTH, 24'd127);
        write_reg(REG_AVERAGE_COUNT, 24'd255);
        for (int k = 0; k < 255; k++)
            send_sample(16'hFFFF, 16'hFFFF);
        settle();
    endtask

    task automatic test_random(int phase);
        int n;
        write_reg(REG_AVERAGE_COUNT, 24'($urandom_range(1, 4)));
        write_reg(REG_REFERENCE_RES, 24'($urandom_range(1, 65535)));
        write_reg(REG_OFFSET_TENTHS, 24'($urandom_range(0, 2000) - 1000));
        write_reg(REG_OPEN_THRESHOLD, 24'($urandom_range(0, 16777215)));
        write_reg(REG_TABLE_LENGTH, 24'($urandom_range(2, 64)));
        if (phase % 2 == 0)
            load_curve(1'b0);
        n = 0;
        while (n < 130)
        begin
            if ($urandom_range(0, 19) == 0)
                send_entry($urandom_range(0, 63), $urandom, $urandom);
            else if ($urandom_range(0, 9) == 0)
                send_sample(16'($urandom), 16'($urandom));
            else
                send_sample(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)));
            n++;
        end
        settle();
    endtask

    task automatic test_backpressure();
        write_reg(REG_AVERAGE_COUNT, 24'd1);
        sink_hold = 1'b1;
        fork
            begin
                wait (sink_hold_cycles >= 3000);
                sink_hold = 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_sample(16'($urandom_range(1, 65535)), 16'($urandom));
        join
        settle();
    endtask

    initial
    begin
        avg_count_q = 8'd16;
        ref_res_q = 16'd3005;
        offset_q = '0;
        open_thr_q = 24'd1000000;
        tab_len_q = 7'd64;
        csum_q = '0;
        vsum_q = '0;
        count_q = '0;
        smooth_q = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            curve_temp[k] = '0;
            curve_res[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        for (int p = 0; p < 6; p++)
            test_random(p);
        quiet = 1'b1;
        test_random(6);
        settle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
